FILE: rtl/core/vasp_pkg.sv
// ----------------------------------------------------------------------------
// vasp_pkg: shared types and constants for the Annex-B stream probe
// NAL type codes, window match constants, verdict codes, header check result.
// ----------------------------------------------------------------------------
`default_nettype none

package vasp_pkg;

   localparam logic [31:0] WIN_RESET  = 32'hFFFF_FFFF;
   localparam logic [31:0] WIN_MASK   = 32'hFFFF_FF00;
   localparam logic [31:0] WIN_START  = 32'h0000_0100;

   localparam logic [6:0]  SCORE_RESET = 7'd50;
   localparam logic [6:0]  SCORE_MAX   = 7'd127;

   // NAL unit types
   localparam logic [4:0] NAL_IDR_W_RADL = 5'd7;
   localparam logic [4:0] NAL_IDR_N_LP   = 5'd8;
   localparam logic [4:0] NAL_CRA        = 5'd9;
   localparam logic [4:0] NAL_GDR        = 5'd10;
   localparam logic [4:0] NAL_RSV_IRAP   = 5'd11;
   localparam logic [4:0] NAL_OPI        = 5'd12;
   localparam logic [4:0] NAL_DCI        = 5'd13;
   localparam logic [4:0] NAL_VPS        = 5'd14;
   localparam logic [4:0] NAL_SPS        = 5'd15;
   localparam logic [4:0] NAL_PPS        = 5'd16;
   localparam logic [4:0] NAL_EOS        = 5'd21;
   localparam logic [4:0] NAL_EOB        = 5'd22;

   localparam logic [2:0] TID_ZERO = 3'd0;
   localparam logic [2:0] TID_BASE = 3'd1;

   // seen flag bits
   localparam int SEEN_SPS  = 0;
   localparam int SEEN_PPS  = 1;
   localparam int SEEN_IRAP = 2;
   localparam logic [2:0] SEEN_ALL = 3'b111;

   // order flag bits
   localparam int ORD_PPS  = 0;
   localparam int ORD_IRAP = 1;

   typedef enum logic [2:0] {
      VERDICT_NONE   = 3'd0,
      VERDICT_SOME   = 3'd1,
      VERDICT_ALL    = 3'd2,
      VERDICT_ORDER  = 3'd3,
      VERDICT_REJECT = 3'd4
   } verdict_type;

   typedef struct packed {
      logic       reject;
      logic [2:0] seen;
      logic [1:0] ord;
   } hdr_result_type;

endpackage

`default_nettype wire

FILE: rtl/core/vvc_annexb_stream_probe_unit.sv
// Pipeline: 2 register stages, the input register and the result register; the
//   result word is valid on rsp_* once the buffer's last word leaves the input register.
// Input: one word per cycle; the input register and stream state update as words
//   are consumed, and a last word waits there, holding back later words, while the result is stalled.
// Reset: synchronous, clears pipeline valids and stream state; score base = 50.
// ----------------------------------------------------------------------------
// vvc_annexb_stream_probe_unit: H.266 Annex-B start code probe
// Scans a byte stream for 00 00 01 start codes, checks NAL headers, tracks
// SPS/PPS/IRAP order and emits a score on the buffer's last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vvc_annexb_stream_probe_unit (
   input  wire logic       clock,
   input  wire logic       reset,
   // input words
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   // result words
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_score,
   output logic [2:0]      rsp_verdict,
   // score base register
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [6:0] csr_extension_score
);

   // ---------------------------------------------------------------- config
   logic [6:0] base_ff, base_in;

   assign csr_ready = 1'b1;
   assign base_in   = (csr_valid && csr_ready) ? csr_extension_score : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= vasp_pkg::SCORE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   // ------------------------------------------------------- input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff, s1_byte_in;
   logic       s1_last_ff, s1_last_in;
   logic       req_take;
   logic       s1_fire;   // stage 1 word consumed this cycle

   // A last word needs a free (or draining) result register.
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || !rsp_valid || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in = req_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign s1_byte_in  = req_take ? req_data_byte : s1_byte_ff;
   assign s1_last_in  = req_take ? req_last_byte : s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
   end

   // --------------------------------------------------------- stream state
   logic [31:0] window_ff, window_in;
   logic        pending_ff, pending_in;
   logic [7:0]  hdr0_ff, hdr0_in;
   logic [2:0]  seen_ff, seen_in;
   logic [1:0]  ord_ff, ord_in;
   logic        rej_ff, rej_in;

   vasp_pkg::hdr_result_type hdr;

   vasp_hdr_decode u_hdr (
      .first_byte  (hdr0_ff),
      .second_byte (s1_byte_ff),
      .seen        (seen_ff),
      .ord         (ord_ff),
      .result      (hdr)
   );

   // state after this word, before the end-of-buffer clear
   logic [31:0] win_shift;
   logic [2:0]  seen_up;
   logic [1:0]  ord_up;
   logic        rej_up;

   assign win_shift = {window_ff[23:0], s1_byte_ff};

   always_comb begin
      seen_up = seen_ff;
      ord_up  = ord_ff;
      rej_up  = rej_ff;
      if (!rej_ff && pending_ff) begin
         rej_up = hdr.reject;
         if (!hdr.reject) begin
            seen_up = hdr.seen;
            ord_up  = hdr.ord;
         end
      end
   end

   always_comb begin
      window_in  = window_ff;
      pending_in = pending_ff;
      hdr0_in    = hdr0_ff;
      seen_in    = seen_ff;
      ord_in     = ord_ff;
      rej_in     = rej_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            // buffer done: back to the reset picture
            window_in  = vasp_pkg::WIN_RESET;
            pending_in = 1'b0;
            hdr0_in    = '0;
            seen_in    = '0;
            ord_in     = '0;
            rej_in     = 1'b0;
         end else if (!rej_ff) begin
            seen_in    = seen_up;
            ord_in     = ord_up;
            rej_in     = rej_up;
            pending_in = 1'b0;
            if (!rej_up) begin
               window_in = win_shift;
               if ((win_shift & vasp_pkg::WIN_MASK) == vasp_pkg::WIN_START) begin
                  pending_in = 1'b1;
                  hdr0_in    = s1_byte_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= vasp_pkg::WIN_RESET;
         pending_ff <= 1'b0;
         hdr0_ff    <= '0;
         seen_ff    <= '0;
         ord_ff     <= '0;
         rej_ff     <= 1'b0;
      end else begin
         window_ff  <= window_in;
         pending_ff <= pending_in;
         hdr0_ff    <= hdr0_in;
         seen_ff    <= seen_in;
         ord_ff     <= ord_in;
         rej_ff     <= rej_in;
      end
   end

   // --------------------------------------------------------------- scoring
   logic [7:0]            base_inc;
   logic [6:0]            score_calc;
   vasp_pkg::verdict_type verdict_calc;

   assign base_inc = {1'b0, base_ff} + 8'd1;

   always_comb begin
      if (rej_up) begin
         score_calc   = '0;
         verdict_calc = vasp_pkg::VERDICT_REJECT;
      end else if (ord_up[vasp_pkg::ORD_IRAP]) begin
         score_calc   = base_inc[7] ? vasp_pkg::SCORE_MAX : base_inc[6:0];
         verdict_calc = vasp_pkg::VERDICT_ORDER;
      end else if (seen_up == vasp_pkg::SEEN_ALL) begin
         score_calc   = {1'b0, base_ff[6:1]};
         verdict_calc = vasp_pkg::VERDICT_ALL;
      end else if (seen_up != '0) begin
         score_calc   = {2'b00, base_ff[6:2]};
         verdict_calc = vasp_pkg::VERDICT_SOME;
      end else begin
         score_calc   = '0;
         verdict_calc = vasp_pkg::VERDICT_NONE;
      end
   end

   // ------------------------------------------------------- result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] rsp_score_ff, rsp_score_in;
   logic [2:0] rsp_verdict_ff, rsp_verdict_in;
   logic       rsp_load;

   assign rsp_load       = s1_fire && s1_last_ff;
   assign rsp_valid_in   = rsp_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   assign rsp_score_in   = rsp_load ? score_calc : rsp_score_ff;
   assign rsp_verdict_in = rsp_load ? 3'(verdict_calc) : rsp_verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_score_ff   <= rsp_score_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_score   = rsp_score_ff;
   assign rsp_verdict = rsp_verdict_ff;

`ifndef SYNTH
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_verdict == 3'(vasp_pkg::VERDICT_REJECT)) |-> rsp_score == '0)
      else $error("rejected stream with nonzero score");

   a_ord_chain: assert property (@(posedge clock) disable iff (reset)
      ord_ff[vasp_pkg::ORD_IRAP] |-> ord_ff[vasp_pkg::ORD_PPS])
      else $error("IRAP order flag without PPS order flag");

   a_ord_seen: assert property (@(posedge clock) disable iff (reset)
      ord_ff[vasp_pkg::ORD_PPS] |->
         seen_ff[vasp_pkg::SEEN_SPS] && seen_ff[vasp_pkg::SEEN_PPS])
      else $error("PPS order flag without SPS and PPS seen");

   a_rej_idle: assert property (@(posedge clock) disable iff (reset)
      rej_ff |-> !pending_ff)
      else $error("header pending on rejected stream");

   a_end_clear: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=>
         (window_ff == vasp_pkg::WIN_RESET) && (seen_ff == '0) && !rej_ff && rsp_valid)
      else $error("stream state not cleared after last word");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/vasp_hdr_decode.sv
// ----------------------------------------------------------------------------
// vasp_hdr_decode: NAL header check and unit tracking
// Checks the two header bytes and returns updated seen/order flags.
// ----------------------------------------------------------------------------
`default_nettype none

module vasp_hdr_decode (
   input  wire logic [7:0]             first_byte,
   input  wire logic [7:0]             second_byte,
   input  wire logic [2:0]             seen,
   input  wire logic [1:0]             ord,
   output vasp_pkg::hdr_result_type    result
);

   logic [4:0] nal_type;
   logic [2:0] tid1;
   logic       tid_limited;   // type allows only temporal id 0

   assign nal_type = second_byte[7:3];
   assign tid1     = second_byte[2:0];

   always_comb begin
      unique case (nal_type) inside
         [vasp_pkg::NAL_IDR_W_RADL:vasp_pkg::NAL_SPS],
         vasp_pkg::NAL_EOS, vasp_pkg::NAL_EOB: tid_limited = 1'b1;
         default:                              tid_limited = 1'b0;
      endcase
   end

   always_comb begin
      result.reject = first_byte[7] || (tid1 == vasp_pkg::TID_ZERO) ||
                      ((tid1 != vasp_pkg::TID_BASE) && tid_limited);
      result.seen   = seen;
      result.ord    = ord;
      if (!result.reject) begin
         unique case (nal_type) inside
            vasp_pkg::NAL_SPS: begin
               result.seen[vasp_pkg::SEEN_SPS] = 1'b1;
            end
            vasp_pkg::NAL_PPS: begin
               if (seen[vasp_pkg::SEEN_SPS]) begin
                  result.ord[vasp_pkg::ORD_PPS] = 1'b1;
               end
               result.seen[vasp_pkg::SEEN_PPS] = 1'b1;
            end
            [vasp_pkg::NAL_IDR_W_RADL:vasp_pkg::NAL_GDR]: begin
               if (ord[vasp_pkg::ORD_PPS]) begin
                  result.ord[vasp_pkg::ORD_IRAP] = 1'b1;
               end
               result.seen[vasp_pkg::SEEN_IRAP] = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire
